@@ rtl/sarc_pkg.sv @@
// Package for the summed-area rectangle counter: field widths, command and
// register codes, item structs and the table access struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sarc_pkg;

    localparam int COORD_W         = 8;
    localparam int COUNT_W         = 17;
    localparam int SIDE_W          = 9;
    localparam int ROWSUM_W        = 9;
    localparam int COORD_LIMIT     = 256;
    localparam int DEF_MAX_SIDE    = 256;
    localparam int GRID_SIDE_RESET = 256;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register index, taken from the word address
    localparam logic REG_GRID_SIDE = 1'b0;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               command;
        logic               cell_bit;
        logic [COORD_W-1:0] top_row;
        logic [COORD_W-1:0] left_col;
        logic [COORD_W-1:0] bottom_row;
        logic [COORD_W-1:0] right_col;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] cell_count;
        logic               range_error;
    } out_item_t;

    // One access to the single-port table
    typedef struct packed {
        logic               we;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COUNT_W-1:0] wdata;
    } tbl_req_t;

endpackage

`default_nettype wire

@@ rtl/sarc_table.sv @@
// Single-port summed-area table memory with registered read data.
// Depends on sarc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sarc_table
    import sarc_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
)
(
    input  wire logic               clk,
    input  wire tbl_req_t           req,
    output      logic [COUNT_W-1:0] rdata
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [AW-1:0]      addr;
    logic [COUNT_W-1:0] rdata_reg;

    // row-major entry address: row * MAX_SIDE + col
    assign addr  = AW'(AW'(req.row) * AW'(MAX_SIDE)) + AW'(req.col);
    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[addr] <= req.wdata;
        end
        rdata_reg <= mem[addr];
    end

endmodule

`default_nettype wire

@@ rtl/summed_area_rectangle_count.sv @@
// Top level of the summed-area rectangle counter: APB register, sequencer,
// shared add/subtract unit and result register.
// Depends on sarc_pkg and sarc_table.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: drive item and raise start; the item is taken at the
//   clock edge where start is high and busy is low.
//   A load item (command 0) writes the next grid cell in row-major order and
//   gives no result. It passes through accept, read of the entry above and
//   write of the new entry.
//   A query item (command 1) gives one result on the result port, marked by
//   done for exactly one cycle. A valid query runs through accept, four
//   table reads and the last accumulate, and done rises the cycle after;
//   the one port of the table serialises the four reads. A reversed or
//   out-of-grid rectangle returns count 0 with range_error in the cycle
//   after accept and leaves busy low.
//   The receiver cannot stall: done marks each result for one cycle only.
//   grid_side sits at APB address 0; a write also restarts loading at the
//   first cell. Reset clears the load position and row sum and sets
//   grid_side to 256; table contents are undefined until loaded.
module summed_area_rectangle_count
    import sarc_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command channel
    input  wire logic                  start,
    output      logic                  busy,
    input  wire in_item_t              item,
    // result channel
    output      logic                  done,
    output      out_item_t             result,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    localparam int SIDE_LIM = (MAX_SIDE < COORD_LIMIT) ? MAX_SIDE : COORD_LIMIT;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LD_RD  = 5'b00010,
        ST_LD_WR  = 5'b00100,
        ST_Q_RD   = 5'b01000,
        ST_Q_LAST = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [SIDE_W-1:0]   grid_side_reg, grid_side_next;
    logic [ROWSUM_W-1:0] row_sum_reg, row_sum_next;
    logic [COORD_W-1:0]  load_row_reg, load_row_next;
    logic [COORD_W-1:0]  load_col_reg, load_col_next;
    logic [COUNT_W-1:0]  acc_reg, acc_next;
    logic [1:0]          step_reg, step_next;
    logic [COORD_W-1:0]  qa_reg, qa_next;
    logic [COORD_W-1:0]  qb_reg, qb_next;
    logic [COORD_W-1:0]  qx_reg, qx_next;
    logic [COORD_W-1:0]  qy_reg, qy_next;
    logic                done_reg, done_next;
    out_item_t           result_reg, result_next;

    logic               accept;
    logic               cfg_wr;
    logic [SIDE_W-1:0]  side;
    logic [COORD_W-1:0] ld_r, ld_c;
    logic               q_err;
    logic [COORD_W-1:0] qa_m1, qb_m1;
    logic [1:0]         acc_idx;
    logic               acc_en;

    // shared add/subtract unit
    logic               alu_load;
    logic               alu_use;
    logic               alu_sub;
    logic [COUNT_W-1:0] alu_base;
    logic [COUNT_W-1:0] alu_opnd;
    logic [COUNT_W-1:0] alu_out;

    tbl_req_t           tbl_req;
    logic [COUNT_W-1:0] tbl_rdata;

    sarc_table #(
        .MAX_SIDE (MAX_SIDE)
    ) u_table (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // APB: zero wait states, register index from the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GRID_SIDE);
    assign prdata = (paddr[2] == REG_GRID_SIDE) ? APB_DATA_W'(grid_side_reg) : '0;

    // Clamp the programmed side to 1..SIDE_LIM
    always_comb
    begin
        if (grid_side_reg == '0)
        begin
            side = SIDE_W'(1);
        end
        else if (grid_side_reg > SIDE_W'(SIDE_LIM))
        begin
            side = SIDE_W'(SIDE_LIM);
        end
        else
        begin
            side = grid_side_reg;
        end
    end

    // Hold the load position inside the grid
    assign ld_r = ({1'b0, load_row_reg} >= side) ? COORD_W'(side - SIDE_W'(1)) : load_row_reg;
    assign ld_c = ({1'b0, load_col_reg} >= side) ? COORD_W'(side - SIDE_W'(1)) : load_col_reg;

    assign q_err = (item.top_row > item.bottom_row) || (item.left_col > item.right_col)
                || ({1'b0, item.bottom_row} >= side) || ({1'b0, item.right_col} >= side);

    assign qa_m1 = (qa_reg == '0) ? '0 : qa_reg - COORD_W'(1);
    assign qb_m1 = (qb_reg == '0) ? '0 : qb_reg - COORD_W'(1);

    // Read data of step k arrives in the cycle after its read is issued
    assign acc_idx = (state_reg == ST_Q_LAST) ? 2'd3 : step_reg - 2'd1;
    assign acc_en  = (state_reg == ST_Q_LAST) || ((state_reg == ST_Q_RD) && (step_reg != 2'd0));

    always_comb
    begin
        alu_load = (state_reg == ST_LD_WR);
        alu_use  = 1'b1;
        alu_sub  = 1'b0;
        if (alu_load)
        begin
            // nothing above the first row
            alu_use = (load_row_reg != '0);
        end
        else
        begin
            case (acc_idx)
                2'd0:    alu_use = 1'b1;
                2'd1:    begin alu_use = (qa_reg != '0); alu_sub = 1'b1; end
                2'd2:    begin alu_use = (qb_reg != '0); alu_sub = 1'b1; end
                2'd3:    alu_use = (qa_reg != '0) && (qb_reg != '0);
                default: alu_use = 1'b0;
            endcase
        end
        alu_base = alu_load ? COUNT_W'(row_sum_reg) : acc_reg;
        alu_opnd = alu_use ? tbl_rdata : '0;
        alu_out  = alu_sub ? alu_base - alu_opnd : alu_base + alu_opnd;
    end

    // Table address and write for the current state
    always_comb
    begin
        tbl_req.we    = 1'b0;
        tbl_req.row   = '0;
        tbl_req.col   = '0;
        tbl_req.wdata = alu_out;
        case (state_reg)
            ST_LD_RD:
            begin
                tbl_req.row = (load_row_reg == '0) ? '0 : load_row_reg - COORD_W'(1);
                tbl_req.col = load_col_reg;
            end
            ST_LD_WR:
            begin
                tbl_req.we  = 1'b1;
                tbl_req.row = load_row_reg;
                tbl_req.col = load_col_reg;
            end
            ST_Q_RD:
            begin
                case (step_reg)
                    2'd0:    begin tbl_req.row = qx_reg; tbl_req.col = qy_reg; end
                    2'd1:    begin tbl_req.row = qa_m1;  tbl_req.col = qy_reg; end
                    2'd2:    begin tbl_req.row = qx_reg; tbl_req.col = qb_m1;  end
                    2'd3:    begin tbl_req.row = qa_m1;  tbl_req.col = qb_m1;  end
                    default: begin tbl_req.row = '0;     tbl_req.col = '0;     end
                endcase
            end
            default:
            begin
                tbl_req.we = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        grid_side_next = grid_side_reg;
        row_sum_next   = row_sum_reg;
        load_row_next  = load_row_reg;
        load_col_next  = load_col_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.command == CMD_LOAD)
                    begin
                        // latch the clamped position and advance the row sum
                        load_row_next = ld_r;
                        load_col_next = ld_c;
                        row_sum_next  = row_sum_reg + ROWSUM_W'(item.cell_bit);
                        state_next    = ST_LD_RD;
                    end
                    else if (q_err)
                    begin
                        done_next               = 1'b1;
                        result_next.cell_count  = '0;
                        result_next.range_error = 1'b1;
                    end
                    else
                    begin
                        qa_next    = item.top_row;
                        qb_next    = item.left_col;
                        qx_next    = item.bottom_row;
                        qy_next    = item.right_col;
                        acc_next   = '0;
                        step_next  = 2'd0;
                        state_next = ST_Q_RD;
                    end
                end
            end
            ST_LD_RD:
            begin
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                if (({1'b0, load_col_reg} + SIDE_W'(1)) >= side)
                begin
                    load_col_next = '0;
                    row_sum_next  = '0;
                    load_row_next = (({1'b0, load_row_reg} + SIDE_W'(1)) >= side)
                                  ? '0 : load_row_reg + COORD_W'(1);
                end
                else
                begin
                    load_col_next = load_col_reg + COORD_W'(1);
                end
                state_next = ST_IDLE;
            end
            ST_Q_RD:
            begin
                if (acc_en)
                begin
                    acc_next = alu_out;
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = ST_Q_LAST;
                end
            end
            ST_Q_LAST:
            begin
                done_next               = 1'b1;
                result_next.cell_count  = alu_out;
                result_next.range_error = 1'b0;
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a side write restarts loading at the first cell
        if (cfg_wr)
        begin
            grid_side_next = pwdata[SIDE_W-1:0];
            row_sum_next   = '0;
            load_row_next  = '0;
            load_col_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grid_side_reg <= SIDE_W'(GRID_SIDE_RESET);
            row_sum_reg   <= '0;
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            step_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grid_side_reg <= grid_side_next;
            row_sum_reg   <= row_sum_next;
            load_row_reg  <= load_row_next;
            load_col_reg  <= load_col_next;
            step_reg      <= step_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        qa_reg     <= qa_next;
        qb_reg     <= qb_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        result_reg <= result_next;
    end

`ifndef SYNTH
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_Q_LAST)
                  || $past(start && !busy && (item.command == CMD_QUERY)))
        else $error("result strobe without a finished query");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.range_error) |-> (result_reg.cell_count == '0))
        else $error("range error with non-zero count");

    a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (({1'b0, load_row_reg} < side) && ({1'b0, load_col_reg} < side)))
        else $error("load position outside the grid");

    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.command == CMD_LOAD)) |=> (state_reg == ST_LD_RD))
        else $error("load item not started");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for summed_area_rectangle_count: a directed table of items, then
// random grids; results checked by an in-bench predictor or typed-in answers.
// Depends on sarc_pkg and the summed_area_rectangle_count RTL.
`timescale 1ns / 1ps

module tb_top;
    import sarc_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 4;
    localparam int GRID_MAX      = (DEF_MAX_SIDE < COORD_LIMIT) ? DEF_MAX_SIDE : COORD_LIMIT;
    localparam int GRID_LAST     = GRID_MAX - 1;
    // opening grid, loaded in full with every cell marked
    localparam int OPEN_SIDE     = 16;
    localparam int OPEN_LAST     = OPEN_SIDE - 1;
    localparam int OPEN_CELLS    = OPEN_SIDE * OPEN_SIDE;
    localparam int PHASE_ITEMS   = 550;
    // attempts at a query that reads only stored entries before falling back
    localparam int QUERY_TRIES   = 256;
    // a load keeps the block busy for its read and write after it is taken
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int TIMEOUT_NS    = 3_000_000;
    localparam int NO_SIDE_WRITE = -1;
    localparam logic [APB_ADDR_W-1:0] GRID_SIDE_ADDR = APB_ADDR_W'(4 * REG_GRID_SIDE);

    // Ways of building a rectangle that the block must reject
    typedef enum int {
        BAD_ROWS,    // top below bottom
        BAD_COLS,    // left right of right
        BAD_BOTTOM,  // bottom row outside the grid
        BAD_RIGHT,   // right column outside the grid
        BAD_ANY      // every field random; may land inside the grid after all
    } broken_kind_e;

    // One row of the directed table: an optional grid_side write, then the
    // same item sent a number of times, with an optional typed-in answer.
    typedef struct packed {
        logic                 wr_side;
        logic [SIDE_W-1:0]    side_val;
        logic [16:0]          repeats;
        in_item_t             it;
        logic                 fixed;
        out_item_t            want;
    } plan_step_t;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  start   = 1'b0;
    in_item_t              item    = '0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic                  busy;
    logic                  done;
    out_item_t             result;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: summed-area table, running row sum, load position
    // and the grid_side register as last written.
    bit [COUNT_W-1:0]  prefix_sum [GRID_MAX][GRID_MAX];
    // entries stored since reset; the others have no defined value
    bit                entry_written [GRID_MAX][GRID_MAX];
    bit [ROWSUM_W-1:0] row_tally    = '0;
    bit [COORD_W-1:0]  fill_row     = '0;
    bit [COORD_W-1:0]  fill_col     = '0;
    bit [SIDE_W-1:0]   side_setting = SIDE_W'(GRID_SIDE_RESET);

    out_item_t  expected_counts [$];
    plan_step_t directed_plan [$];
    out_item_t  oldest;
    int         mismatch_count  = 0;
    int         item_total      = 0;
    int         sender_idle_pct = 20;

    summed_area_rectangle_count dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop in case the block hangs or never answers a query.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns  MISMATCH  %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Side in use: zero acts as one, anything past the table is clamped.
    function automatic int clamped_side();
        int s;
        s = side_setting;
        if (s < 1)
            s = 1;
        if (s > GRID_MAX)
            s = GRID_MAX;
        return s;
    endfunction

    // Store the next cell: row sum so far plus the entry directly above,
    // then advance the load position, wrapping at the end of a row or grid.
    function automatic void advance_prefix_load(input logic mark);
        int               s;
        int               r;
        int               c;
        bit [COUNT_W-1:0] above;
        s = clamped_side();
        r = fill_row;
        c = fill_col;
        // a position left past the side by a shrinking grid counts as its end
        if (r >= s)
            r = s - 1;
        if (c >= s)
            c = s - 1;
        row_tally = row_tally + mark;
        above = (r > 0) ? prefix_sum[r - 1][c] : '0;
        prefix_sum[r][c]    = row_tally + above;
        entry_written[r][c] = 1'b1;
        if (c + 1 >= s)
        begin
            fill_col  = '0;
            row_tally = '0;
            fill_row  = (r + 1 >= s) ? '0 : COORD_W'(r + 1);
        end
        else
        begin
            fill_col = COORD_W'(c + 1);
            fill_row = COORD_W'(r);
        end
    endfunction

    // Inclusion-exclusion over up to four corners; counts wrap at 17 bits,
    // which matters when a half-reloaded grid mixes old and new entries.
    function automatic out_item_t predict_cell_count(input in_item_t q);
        int               s;
        int               a;
        int               b;
        int               x;
        int               y;
        bit [COUNT_W-1:0] total;
        out_item_t        res;
        s = clamped_side();
        a = q.top_row;
        b = q.left_col;
        x = q.bottom_row;
        y = q.right_col;
        res = '0;
        if (a > x || b > y || x >= s || y >= s)
        begin
            res.range_error = 1'b1;
            return res;
        end
        total = prefix_sum[x][y];
        if (a > 0)
            total -= prefix_sum[a - 1][y];
        if (b > 0)
            total -= prefix_sum[x][b - 1];
        if (a > 0 && b > 0)
            total += prefix_sum[a - 1][b - 1];
        res.cell_count = total;
        return res;
    endfunction

    // True when the query is rejected, or every corner that it uses has
    // been stored since reset.
    function automatic logic reads_stored(input in_item_t q);
        int s;
        int a;
        int b;
        int x;
        int y;
        s = clamped_side();
        a = q.top_row;
        b = q.left_col;
        x = q.bottom_row;
        y = q.right_col;
        if (a > x || b > y || x >= s || y >= s)
            return 1'b1;
        if (!entry_written[x][y])
            return 1'b0;
        if (a > 0 && !entry_written[a - 1][y])
            return 1'b0;
        if (b > 0 && !entry_written[x][b - 1])
            return 1'b0;
        if (a > 0 && b > 0 && !entry_written[a - 1][b - 1])
            return 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: done marks a result for one cycle only, so take it
    // at every edge where it is high and match it with the oldest query.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (done === 1'b1)
        begin
            if (expected_counts.size() == 0)
            begin
                report_mismatch($sformatf("result with no query waiting: count %0d error %0b",
                                          result.cell_count, result.range_error));
            end
            else
            begin
                oldest = expected_counts.pop_front();
                if (result.cell_count !== oldest.cell_count)
                    report_mismatch($sformatf("cell_count %0d, predicted %0d",
                                              result.cell_count, oldest.cell_count));
                if (result.range_error !== oldest.range_error)
                    report_mismatch($sformatf("range_error %0b, predicted %0b",
                                              result.range_error, oldest.range_error));
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // One APB transfer to grid_side: setup cycle, then access until pready.
    // Ends with the bus returned to idle, so back-to-back calls never clash.
    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= GRID_SIDE_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write grid_side, mirror it in the predictor (the write also restarts
    // loading at the first cell) and read it back.
    task automatic set_grid_side(input logic [SIDE_W-1:0] side);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, APB_DATA_W'(side), rd);
        side_setting = side;
        row_tally    = '0;
        fill_row     = '0;
        fill_col     = '0;
        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(side))
            report_mismatch($sformatf("grid_side read back %0d, written %0d", rd, side));
    endtask

    // ------------------------------------------------------------------
    // Command channel
    // ------------------------------------------------------------------

    // Drop start and hold it low until every query has answered; the wait
    // steps the clock first, so start is never lowered and raised at once.
    task automatic hold_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_counts.size() != 0);
    endtask

    // Bring the block to rest before a register write: drain the answers,
    // let a trailing load finish, and wait for busy to fall.
    task automatic quiesce();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Present one item, idling at random first, and wait for the edge that
    // takes it. start stays high on return; the caller either follows with
    // the next item or drops start in this same step.
    task automatic send_item(input in_item_t it, input logic fixed, input out_item_t want);
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        item  <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (it.command == CMD_QUERY)
            expected_counts.push_back(fixed ? want : predict_cell_count(it));
        else
            advance_prefix_load(it.cell_bit);
        item_total++;
    endtask

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------

    // Every field random, so each bit of each field sees both values; the
    // block ignores the fields that the command does not use.
    function automatic in_item_t noise_item(input logic cmd);
        in_item_t it;
        it.command    = cmd;
        it.cell_bit   = 1'($urandom_range(1, 0));
        it.top_row    = COORD_W'($urandom_range(255, 0));
        it.left_col   = COORD_W'($urandom_range(255, 0));
        it.bottom_row = COORD_W'($urandom_range(255, 0));
        it.right_col  = COORD_W'($urandom_range(255, 0));
        return it;
    endfunction

    // Rectangle inside the grid, biased towards the borders where fewer
    // corner reads are needed.
    function automatic in_item_t valid_query(input int s);
        in_item_t it;
        it = noise_item(CMD_QUERY);
        it.bottom_row = COORD_W'(($urandom_range(7, 0) == 0) ? s - 1 : $urandom_range(s - 1, 0));
        it.right_col  = COORD_W'(($urandom_range(7, 0) == 0) ? s - 1 : $urandom_range(s - 1, 0));
        it.top_row    = COORD_W'(($urandom_range(3, 0) == 0) ? 0
                                 : $urandom_range(it.bottom_row, 0));
        it.left_col   = COORD_W'(($urandom_range(3, 0) == 0) ? 0
                                 : $urandom_range(it.right_col, 0));
        return it;
    endfunction

    function automatic in_item_t broken_query(input int s);
        in_item_t     it;
        broken_kind_e kind;
        it = noise_item(CMD_QUERY);
        kind = broken_kind_e'($urandom_range(4, 0));
        // with the full grid in use nothing lies outside it; reverse instead
        if ((kind == BAD_BOTTOM || kind == BAD_RIGHT) && s >= GRID_MAX)
            kind = BAD_ROWS;
        case (kind)
            BAD_ROWS:
            begin
                it.top_row    = COORD_W'($urandom_range(255, 1));
                it.bottom_row = COORD_W'($urandom_range(it.top_row - 1, 0));
            end
            BAD_COLS:
            begin
                it.left_col  = COORD_W'($urandom_range(255, 1));
                it.right_col = COORD_W'($urandom_range(it.left_col - 1, 0));
            end
            BAD_BOTTOM:
            begin
                it.bottom_row = COORD_W'($urandom_range(255, s));
                it.top_row    = COORD_W'($urandom_range(it.bottom_row, 0));
            end
            BAD_RIGHT:
            begin
                it.right_col = COORD_W'($urandom_range(255, s));
                it.left_col  = COORD_W'($urandom_range(it.right_col, 0));
            end
            default:
            begin
            end
        endcase
        return it;
    endfunction

    function automatic plan_step_t load_step(input int side, input int reps, input logic mark);
        plan_step_t st;
        st = '0;
        st.wr_side     = (side != NO_SIDE_WRITE);
        st.side_val    = SIDE_W'(side);
        st.repeats     = 17'(reps);
        st.it.command  = CMD_LOAD;
        st.it.cell_bit = mark;
        return st;
    endfunction

    // fixed set: the answer is typed in; otherwise the predictor supplies it
    function automatic plan_step_t query_step(input int t, input int l, input int b,
                                              input int r, input logic fixed,
                                              input int count, input logic err);
        plan_step_t st;
        st = '0;
        st.repeats          = 17'd1;
        st.it.command       = CMD_QUERY;
        st.it.top_row       = COORD_W'(t);
        st.it.left_col      = COORD_W'(l);
        st.it.bottom_row    = COORD_W'(b);
        st.it.right_col     = COORD_W'(r);
        st.fixed            = fixed;
        st.want.cell_count  = COUNT_W'(count);
        st.want.range_error = err;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Random grids: write a side, load the grid (mostly in full, sometimes
    // only part of it, sometimes past its end), then query it with a mix of
    // good rectangles, rejected ones and stray loads.
    // ------------------------------------------------------------------

    task automatic run_random_phase(input int idle_pct);
        int first_item;
        int pick;
        int side;
        int s;
        int density;
        int n_load;
        int n_query;
        int tries;
        in_item_t it;
        sender_idle_pct = idle_pct;
        first_item = item_total;
        while (item_total - first_item < PHASE_ITEMS)
        begin
            // mostly small grids; now and then zero, or a side from one
            // below the table size up, which only gets a partial load
            pick = $urandom_range(99, 0);
            if (pick < 70)
                side = $urandom_range(8, 1);
            else if (pick < 88)
                side = $urandom_range(16, 9);
            else if (pick < 94)
                side = $urandom_range(2, 0);
            else
                side = $urandom_range(511, GRID_LAST);
            quiesce();
            set_grid_side(SIDE_W'(side));
            s = clamped_side();

            density = $urandom_range(100, 0);
            if (s > 16)
                n_load = $urandom_range(2 * s, 0);
            else if ($urandom_range(3, 0) == 0)
                n_load = $urandom_range(s * s - 1, 0);
            else
                n_load = s * s + (($urandom_range(3, 0) == 0) ? $urandom_range(s, 1) : 0);

            repeat (n_load)
            begin
                if ($urandom_range(99, 0) < 2)
                    hold_until_drained();
                it = noise_item(CMD_LOAD);
                it.cell_bit = ($urandom_range(99, 0) < density);
                send_item(it, 1'b0, '0);
            end

            n_query = $urandom_range(10, 2);
            repeat (n_query)
            begin
                if ($urandom_range(99, 0) < 2)
                    hold_until_drained();
                pick = $urandom_range(99, 0);
                if (pick < 8)
                begin
                    it = noise_item(CMD_LOAD);
                end
                else
                begin
                    // keep to rectangles whose corners have all been loaded
                    tries = 0;
                    do
                    begin
                        it = (pick < 26) ? broken_query(s) : valid_query(s);
                        tries++;
                    end
                    while (!reads_stored(it) && tries < QUERY_TRIES);
                    // nothing suitable found: fall back to a reversed rectangle
                    if (!reads_stored(it))
                    begin
                        it.top_row    = COORD_W'(1);
                        it.bottom_row = COORD_W'(0);
                    end
                end
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_seq
        logic [APB_DATA_W-1:0] rd;

        // Small grid, every cell marked and loaded in full; the directed
        // queries below stay inside it or read only what is loaded later.
        directed_plan.push_back(load_step(OPEN_SIDE, OPEN_CELLS, 1'b1));
        directed_plan.push_back(query_step(0, 0, OPEN_LAST, OPEN_LAST,
                                           1'b1, OPEN_CELLS, 1'b0));
        directed_plan.push_back(query_step(OPEN_LAST, OPEN_LAST, OPEN_LAST, OPEN_LAST,
                                           1'b1, 1, 1'b0));
        directed_plan.push_back(query_step(0, 0, 0, 0, 1'b1, 1, 1'b0));
        directed_plan.push_back(query_step(0, OPEN_LAST, OPEN_LAST, OPEN_LAST,
                                           1'b1, OPEN_SIDE, 1'b0));
        directed_plan.push_back(query_step(2, 3, 10, 12, 1'b1, 90, 1'b0));
        directed_plan.push_back(query_step(OPEN_LAST, 0, 0, 0, 1'b1, 0, 1'b1));
        directed_plan.push_back(query_step(0, 0, OPEN_SIDE, 0, 1'b1, 0, 1'b1));
        directed_plan.push_back(query_step(0, 0, 0, OPEN_SIDE, 1'b1, 0, 1'b1));
        // Oversized side clamps to the full grid; overwrite the first three
        // cells only, then query across old and new entries (wraps below zero)
        directed_plan.push_back(load_step(511, 3, 1'b0));
        directed_plan.push_back(query_step(0, 0, 0, 2, 1'b1, 0, 1'b0));
        directed_plan.push_back(query_step(1, 3, 1, 3, 1'b0, 0, 1'b0));
        directed_plan.push_back(query_step(0, 3, 0, 3, 1'b0, 0, 1'b0));
        // 2x2 grid: 1 0 / 1 1
        directed_plan.push_back(load_step(2, 1, 1'b1));
        directed_plan.push_back(load_step(NO_SIDE_WRITE, 1, 1'b0));
        directed_plan.push_back(load_step(NO_SIDE_WRITE, 2, 1'b1));
        directed_plan.push_back(query_step(0, 0, 1, 1, 1'b1, 3, 1'b0));
        directed_plan.push_back(query_step(1, 1, 1, 1, 1'b1, 1, 1'b0));
        directed_plan.push_back(query_step(0, 1, 1, 1, 1'b1, 1, 1'b0));
        directed_plan.push_back(query_step(1, 0, 1, 1, 1'b1, 2, 1'b0));
        directed_plan.push_back(query_step(1, 0, 0, 1, 1'b1, 0, 1'b1));
        directed_plan.push_back(query_step(0, 1, 1, 0, 1'b1, 0, 1'b1));
        directed_plan.push_back(query_step(0, 0, 2, 1, 1'b1, 0, 1'b1));
        directed_plan.push_back(query_step(0, 0, 1, 2, 1'b1, 0, 1'b1));
        // grid full: the next load wraps to the first cell
        directed_plan.push_back(load_step(NO_SIDE_WRITE, 1, 1'b0));
        directed_plan.push_back(query_step(0, 0, 0, 0, 1'b1, 0, 1'b0));
        directed_plan.push_back(query_step(1, 1, 1, 1, 1'b0, 0, 1'b0));
        // side zero acts as one
        directed_plan.push_back(load_step(0, 1, 1'b1));
        directed_plan.push_back(query_step(0, 0, 0, 0, 1'b1, 1, 1'b0));
        directed_plan.push_back(query_step(0, 0, 0, 1, 1'b1, 0, 1'b1));
        directed_plan.push_back(query_step(0, 0, 1, 0, 1'b1, 0, 1'b1));
        directed_plan.push_back(load_step(1, 1, 1'b0));
        directed_plan.push_back(query_step(0, 0, 0, 0, 1'b1, 0, 1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, '0, rd);
        if (rd !== APB_DATA_W'(GRID_SIDE_RESET))
            report_mismatch($sformatf("grid_side after reset %0d, want %0d",
                                      rd, GRID_SIDE_RESET));

        // Walk the directed table
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].wr_side)
            begin
                quiesce();
                set_grid_side(directed_plan[i].side_val);
            end
            repeat (directed_plan[i].repeats)
                send_item(directed_plan[i].it, directed_plan[i].fixed, directed_plan[i].want);
        end

        // Sender gaps: light, heavy, then none
        run_random_phase(20);
        run_random_phase(62);
        run_random_phase(0);

        // Drain, then give a late or stray result time to show up
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_counts.size() != 0)
            report_mismatch($sformatf("%0d queries never answered", expected_counts.size()));

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
